// ----- sv/text_console_writer_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, off while reset is held.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, checked through reset as well.
`define TCW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

// ----- sv/tcw_pkg.sv -----
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int CELL_W      = 16;

    localparam logic [7:0]        NEWLINE_CODE = 8'd10;
    localparam logic [7:0]        DEF_ATTR     = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

    typedef enum logic [1:0] {
        FN_PUT   = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2
    } tcw_func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } tcw_state_t;

endpackage

// ----- sv/tcw_cell_ram.sv -----
module tcw_cell_ram import tcw_pkg::*; #(
    parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEF_ROWS * DEF_COLUMNS)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] cell_mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/text_console_writer.sv -----
// Text console writer: a ROWS x COLUMNS store of 16-bit cells (character in the
// low byte, attribute in the high byte) with a cursor, kept in one synchronous
// memory with one write and one read port. Each request gets exactly one
// response. A put that runs past the last row scrolls: every cell below the top
// row is copied one row up and the bottom row is filled with blanks, all through
// the single write port. A clear writes every cell once. After reset the memory
// is zeroed in a pass over every cell during which s_tready stays low; attribute
// writes are taken at any time.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_row[4:0], cursor_col[11:5], cell_char[19:12],
                                   // cell_attr[27:20], scrolled[28]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_attribute[7:0]
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

    tcw_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        attr_reg;
    logic              scr_reg, scr_next;
    logic              hit_reg, hit_next;
    logic              cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0] cp_dst_reg, cp_dst_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data, rd_data, cell_out;

    tcw_func_t         in_func;
    logic [7:0]        in_char;
    logic [4:0]        in_row;
    logic [6:0]        in_col;
    logic              accept, in_range, newline, wrap, row_end;
    logic [ADDR_W-1:0] put_addr, rd_addr_in;

    assign in_func = tcw_func_t'(s_tuser);
    assign in_char = s_tdata[7:0];
    assign in_row  = s_tdata[12:8];
    assign in_col  = s_tdata[19:13];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_range   = (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);
    assign put_addr   = ADDR_W'(row_reg) * ROW_STEP + ADDR_W'(col_reg);
    assign rd_addr_in = ADDR_W'(in_row) * ROW_STEP + ADDR_W'(in_col);
    assign newline    = (in_char == NEWLINE_CODE);
    assign wrap       = newline || (col_reg == LAST_COL);
    assign row_end    = (row_reg == LAST_ROW);
    assign cell_out   = hit_reg ? rd_data : '0;

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            attr_reg     <= DEF_ATTR;
            cp_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cp_valid_reg <= cp_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scr_reg     <= scr_next;
        hit_reg     <= hit_next;
        cp_dst_reg  <= cp_dst_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scr_next      = scr_reg;
        hit_next      = hit_reg;
        cp_valid_next = 1'b0;
        cp_dst_next   = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = cnt_reg + ROW_STEP;

        unique case (state_reg)
            ST_INIT: begin
                wr_en = 1'b1;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    scr_next   = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                    unique case (in_func)
                        FN_PUT: begin
                            if (!newline) begin
                                wr_en   = 1'b1;
                                wr_addr = put_addr;
                                wr_data = {attr_reg, in_char};
                            end
                            if (wrap) begin
                                col_next = '0;
                                if (row_end) begin
                                    scr_next   = 1'b1;
                                    cnt_next   = '0;
                                    state_next = ST_SCROLL;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        FN_READ: begin
                            rd_en    = in_range;
                            rd_addr  = rd_addr_in;
                            hit_next = in_range;
                        end
                        FN_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                rd_en         = 1'b1;
                cp_valid_next = 1'b1;
                if (cp_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = cp_dst_reg;
                    wr_data = rd_data;
                end
                if (cnt_reg == COPY_LAST) begin
                    cnt_next   = FILL_FIRST;
                    state_next = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (cp_valid_reg) begin
                    wr_addr = cp_dst_reg;
                    wr_data = rd_data;
                end else begin
                    wr_data = BLANK_CELL;
                    if (cnt_reg == LAST_ADDR) begin
                        cnt_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, scr_reg, cell_out[15:8], cell_out[7:0],
                                     7'(col_reg), 5'(row_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/tcw_checker.sv -----
`include "text_console_writer_macros.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `TCW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TCW_ASSERT_NEXT_ALWAYS(a_init_busy, aclk, !aresetn, !s_tready)
    `TCW_ASSERT_IMPL(a_scroll_pos, aclk, aresetn, m_tvalid && m_tdata[28], (m_tdata[11:5] == 7'd0) && (m_tdata[4:0] == 5'(ROWS - 1)))
    `TCW_ASSERT_IMPL(a_col_range, aclk, aresetn, m_tvalid, int'(m_tdata[11:5]) < COLUMNS)

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
